[rtl/core/nsf_pkg.sv]
// Package for the NMEA sentence framer.
// Holds request codes, trailer phases, the emitted byte record and the hex digit helper.
// No dependencies.
package nsf_pkg;

  localparam logic [1:0] REQ_CHAR  = 2'd0;
  localparam logic [1:0] REQ_FIELD = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  typedef enum logic [2:0] {
    TR_STAR,
    TR_HI,
    TR_LO,
    TR_CR,
    TR_LF
  } trailer_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       send;
    logic [7:0] sum;
  } byte_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [3:0] n;
    n = v & NIBBLE_MASK;
    if (n < 4'd10) begin
      hex_digit = 8'h30 + {4'd0, n};
    end else begin
      hex_digit = 8'h41 + {4'd0, n} - 8'd10;
    end
  endfunction

endpackage

[rtl/core/nmea_sentence_framer_core.sv]
// Top level of the NMEA 0183 sentence framer.
// Joins the byte sequencer nsf_seq and the output register nsf_out; uses nsf_pkg.
// Each request yields one byte per cycle while the output register is not stalled: a field character
// or field close yields one byte, two when it opens a sentence with its delimiter, and a sentence
// close yields five bytes (six when it opens the sentence), all emitted by the sequencer into
// the output register. Request code 3 is taken and dropped without output. A new request
// is taken in the cycle in which the last byte of the previous one enters the output register.
module nmea_sentence_framer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] char_byte,
  input  logic       encapsulated,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       run_last,
  output logic       sentence_end,
  output logic [7:0] checksum_value
);

  logic           out_ready;
  logic           emit;
  nsf_pkg::byte_t emit_byte;

  nsf_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .char_byte    (char_byte),
    .encapsulated (encapsulated),
    .out_ready    (out_ready),
    .emit         (emit),
    .emit_byte    (emit_byte)
  );

  nsf_out u_out (
    .clk            (clk),
    .rst            (rst),
    .emit           (emit),
    .emit_byte      (emit_byte),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .run_last       (run_last),
    .sentence_end   (sentence_end),
    .checksum_value (checksum_value)
  );

endmodule

[rtl/core/nsf_seq.sv]
// Request holding register and byte sequencer of the NMEA sentence framer.
// Emits one sentence byte per cycle while the output register is ready, and keeps the sentence state and running XOR.
// Depends on nsf_pkg.
module nsf_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [7:0]        char_byte,
  input  logic              encapsulated,
  input  logic              out_ready,
  output logic              emit,
  output nsf_pkg::byte_t    emit_byte
);

  logic                 hold_valid;
  logic [1:0]           hold_req;
  logic [7:0]           hold_ch;
  logic                 hold_enc;
  nsf_pkg::trailer_t    phase;
  nsf_pkg::trailer_t    phase_next;
  logic                 in_sentence;
  logic                 in_sentence_next;
  logic [7:0]           running_xor;
  logic [7:0]           running_xor_next;
  logic                 accept;

  assign emit     = hold_valid && out_ready;
  assign in_stall = hold_valid && !(emit && emit_byte.last);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    emit_byte        = '0;
    phase_next       = phase;
    in_sentence_next = in_sentence;
    running_xor_next = running_xor;
    if (!in_sentence) begin
      emit_byte.ch     = hold_enc ? nsf_pkg::CH_BANG : nsf_pkg::CH_DOLLAR;
      emit_byte.sum    = 8'd0;
      in_sentence_next = 1'b1;
      running_xor_next = 8'd0;
    end else begin
      case (hold_req)
        nsf_pkg::REQ_CHAR: begin
          running_xor_next = running_xor ^ hold_ch;
          emit_byte.ch     = hold_ch;
          emit_byte.sum    = running_xor_next;
          emit_byte.last   = 1'b1;
        end
        nsf_pkg::REQ_FIELD: begin
          running_xor_next = running_xor ^ nsf_pkg::CH_COMMA;
          emit_byte.ch     = nsf_pkg::CH_COMMA;
          emit_byte.sum    = running_xor_next;
          emit_byte.last   = 1'b1;
        end
        default: begin
          emit_byte.sum = running_xor;
          case (phase)
            nsf_pkg::TR_STAR: begin
              emit_byte.ch = nsf_pkg::CH_STAR;
              phase_next   = nsf_pkg::TR_HI;
            end
            nsf_pkg::TR_HI: begin
              emit_byte.ch = nsf_pkg::hex_digit(running_xor[7:4]);
              phase_next   = nsf_pkg::TR_LO;
            end
            nsf_pkg::TR_LO: begin
              emit_byte.ch = nsf_pkg::hex_digit(running_xor[3:0]);
              phase_next   = nsf_pkg::TR_CR;
            end
            nsf_pkg::TR_CR: begin
              emit_byte.ch = nsf_pkg::CH_CR;
              phase_next   = nsf_pkg::TR_LF;
            end
            default: begin
              emit_byte.ch     = nsf_pkg::CH_LF;
              emit_byte.last   = 1'b1;
              emit_byte.send   = 1'b1;
              phase_next       = nsf_pkg::TR_STAR;
              in_sentence_next = 1'b0;
              running_xor_next = 8'd0;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid  <= 1'b0;
      phase       <= nsf_pkg::TR_STAR;
      in_sentence <= 1'b0;
      running_xor <= 8'd0;
    end else begin
      if (emit) begin
        phase       <= phase_next;
        in_sentence <= in_sentence_next;
        running_xor <= running_xor_next;
      end
      if (accept) begin
        hold_valid <= (req_type != nsf_pkg::REQ_NONE);
      end else if (emit && emit_byte.last) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_req <= req_type;
      hold_ch  <= char_byte;
      hold_enc <= encapsulated;
    end
  end

endmodule

[rtl/core/nsf_out.sv]
// Output register of the NMEA sentence framer.
// Holds one emitted byte until the receiver takes it; depends on nsf_pkg.
module nsf_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              emit,
  input  nsf_pkg::byte_t    emit_byte,
  output logic              out_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              run_last,
  output logic              sentence_end,
  output logic [7:0]        checksum_value
);

  nsf_pkg::byte_t held;

  assign out_ready      = !out_valid || !out_stall;
  assign out_char       = held.ch;
  assign run_last       = held.last;
  assign sentence_end   = held.send;
  assign checksum_value = held.sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      held <= emit_byte;
    end
  end

endmodule

[test/nmea_sentence_framer_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for nmea_sentence_framer_core: directed table, then random sentences and request bursts.
// Depends on nsf_pkg for request codes and character constants and on the framer RTL.
module nmea_sentence_framer_core_tb;

  localparam int RND_ITEMS = 400;
  localparam int CYC_LIMIT = 400000;
  localparam int DIR_ROWS  = 25;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       send;
    logic [7:0] sum;
  } line_byte_t;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] ch;
    logic       enc;
    logic       fixed;
    logic [2:0] x_n;
    logic [7:0] x_ch;
    logic [7:0] x_sum;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] req_type;
  logic [7:0] char_byte;
  logic       encapsulated;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       run_last;
  logic       sentence_end;
  logic [7:0] checksum_value;

  line_byte_t line_q[$];
  line_byte_t want;
  logic       frm_open = 1'b0;
  logic [7:0] frm_xor  = 8'h00;
  int         err_cnt    = 0;
  int         cyc        = 0;
  int         req_cnt    = 0;
  int         byte_cnt   = 0;
  int         close_cnt  = 0;
  int         fresh_cnt  = 0;
  int         snd_burst  = 0;
  int         rcv_burst  = 0;

  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{nsf_pkg::REQ_NONE,  8'hFF, 1'b1, 1'b1, 3'd0, 8'h00, 8'h00},
    '{nsf_pkg::REQ_CLOSE, 8'h00, 1'b0, 1'b1, 3'd6, nsf_pkg::CH_LF, 8'h00},
    '{nsf_pkg::REQ_CLOSE, 8'h5A, 1'b1, 1'b1, 3'd6, nsf_pkg::CH_LF, 8'h00},
    '{nsf_pkg::REQ_CHAR,  8'h00, 1'b1, 1'b1, 3'd2, 8'h00, 8'h00},
    '{nsf_pkg::REQ_NONE,  8'h2A, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00},
    '{nsf_pkg::REQ_CHAR,  8'hFF, 1'b0, 1'b1, 3'd1, 8'hFF, 8'hFF},
    '{nsf_pkg::REQ_FIELD, 8'h00, 1'b1, 1'b1, 3'd1, nsf_pkg::CH_COMMA, 8'hD3},
    '{nsf_pkg::REQ_CHAR,  nsf_pkg::CH_STAR, 1'b0, 1'b1, 3'd1, nsf_pkg::CH_STAR, 8'hF9},
    '{nsf_pkg::REQ_CHAR,  nsf_pkg::CH_DOLLAR, 1'b1, 1'b1, 3'd1, nsf_pkg::CH_DOLLAR, 8'hDD},
    '{nsf_pkg::REQ_CHAR,  nsf_pkg::CH_BANG, 1'b0, 1'b1, 3'd1, nsf_pkg::CH_BANG, 8'hFC},
    '{nsf_pkg::REQ_CHAR,  nsf_pkg::CH_COMMA, 1'b0, 1'b1, 3'd1, nsf_pkg::CH_COMMA, 8'hD0},
    '{nsf_pkg::REQ_CLOSE, 8'h00, 1'b1, 1'b1, 3'd5, nsf_pkg::CH_LF, 8'hD0},
    '{nsf_pkg::REQ_FIELD, 8'h00, 1'b0, 1'b1, 3'd2, nsf_pkg::CH_COMMA, 8'h2C},
    '{nsf_pkg::REQ_CLOSE, 8'h00, 1'b0, 1'b1, 3'd5, nsf_pkg::CH_LF, 8'h2C},
    '{nsf_pkg::REQ_CHAR,  8'h47, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00},
    '{nsf_pkg::REQ_CHAR,  8'h50, 1'b1, 1'b0, 3'd0, 8'h00, 8'h00},
    '{nsf_pkg::REQ_CHAR,  8'h47, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00},
    '{nsf_pkg::REQ_CHAR,  8'h47, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00},
    '{nsf_pkg::REQ_CHAR,  8'h41, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00},
    '{nsf_pkg::REQ_FIELD, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00},
    '{nsf_pkg::REQ_CHAR,  8'h31, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00},
    '{nsf_pkg::REQ_CLOSE, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00},
    '{nsf_pkg::REQ_CHAR,  8'h80, 1'b1, 1'b1, 3'd2, 8'h80, 8'h80},
    '{nsf_pkg::REQ_CHAR,  8'h7F, 1'b0, 1'b1, 3'd1, 8'h7F, 8'hFF},
    '{nsf_pkg::REQ_CLOSE, 8'h00, 1'b0, 1'b1, 3'd5, nsf_pkg::CH_LF, 8'hFF}
  };

  nmea_sentence_framer_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .char_byte      (char_byte),
    .encapsulated   (encapsulated),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .run_last       (run_last),
    .sentence_end   (sentence_end),
    .checksum_value (checksum_value)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_err(input string msg);
    if (err_cnt < 40) $display("mismatch at cycle %0d: %s", cyc, msg);
    err_cnt++;
  endtask

  task automatic pick_wait(inout int burst, output int w);
    if (burst > 0) begin
      burst--;
      w = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      w = 0;
    end else begin
      w = $urandom_range(0, 11);
    end
  endtask

  function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h41 - 8'd10 + {4'd0, v};
  endfunction

  // Queues the bytes one accepted request should produce and advances the framer state.
  task automatic frame_request(input logic [1:0] r, input logic [7:0] c, input logic e);
    logic [7:0] s;
    if (r == nsf_pkg::REQ_NONE) return;
    if (!frm_open) begin
      frm_xor = 8'h00;
      line_q.push_back('{e ? nsf_pkg::CH_BANG : nsf_pkg::CH_DOLLAR, 1'b0, 1'b0, 8'h00});
      frm_open = 1'b1;
    end
    case (r)
      nsf_pkg::REQ_CHAR: begin
        frm_xor = frm_xor ^ c;
        line_q.push_back('{c, 1'b1, 1'b0, frm_xor});
      end
      nsf_pkg::REQ_FIELD: begin
        frm_xor = frm_xor ^ nsf_pkg::CH_COMMA;
        line_q.push_back('{nsf_pkg::CH_COMMA, 1'b1, 1'b0, frm_xor});
      end
      default: begin
        s = frm_xor;
        line_q.push_back('{nsf_pkg::CH_STAR, 1'b0, 1'b0, s});
        line_q.push_back('{nibble_ascii(s[7:4]), 1'b0, 1'b0, s});
        line_q.push_back('{nibble_ascii(s[3:0]), 1'b0, 1'b0, s});
        line_q.push_back('{nsf_pkg::CH_CR, 1'b0, 1'b0, s});
        line_q.push_back('{nsf_pkg::CH_LF, 1'b1, 1'b1, s});
        frm_open = 1'b0;
        frm_xor = 8'h00;
      end
    endcase
  endtask

  // Entered and left at a falling edge.
  task automatic issue(input logic [1:0] r, input logic [7:0] c, input logic e);
    int gap;
    int sz;
    pick_wait(snd_burst, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= r;
    char_byte    <= c;
    encapsulated <= e;
    do @(posedge clk); while (in_stall);
    sz = line_q.size();
    frame_request(r, c, e);
    fresh_cnt = line_q.size() - sz;
    if (r != nsf_pkg::REQ_NONE) req_cnt++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (line_q.size() != 0);
  endtask

  task automatic random_sentence();
    int nh;
    int nf;
    int nc;
    nh = $urandom_range(2, 5);
    repeat (nh)
      issue(nsf_pkg::REQ_CHAR, 8'($urandom_range(8'h41, 8'h5A)), 1'($urandom_range(0, 1)));
    nf = $urandom_range(0, 6);
    repeat (nf) begin
      issue(nsf_pkg::REQ_FIELD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      nc = $urandom_range(0, 6);
      repeat (nc) begin
        if ($urandom_range(0, 19) == 0)
          issue(nsf_pkg::REQ_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) == 0)
          issue(nsf_pkg::REQ_CHAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
          issue(nsf_pkg::REQ_CHAR, 8'($urandom_range(8'h20, 8'h7E)),
                1'($urandom_range(0, 1)));
      end
    end
    issue(nsf_pkg::REQ_CLOSE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("timeout after %0d cycles with %0d bytes still due", cyc, line_q.size());
      $display("nmea_sentence_framer_core_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      byte_cnt++;
      if (sentence_end) close_cnt++;
      if (line_q.size() == 0) begin
        report_err($sformatf("unexpected byte %h", out_char));
      end else begin
        want = line_q.pop_front();
        if (out_char !== want.ch)
          report_err($sformatf("out_char %h, want %h", out_char, want.ch));
        if (run_last !== want.last)
          report_err($sformatf("run_last %b, want %b on %h", run_last, want.last, want.ch));
        if (sentence_end !== want.send)
          report_err($sformatf("sentence_end %b, want %b on %h", sentence_end, want.send,
                               want.ch));
        if (checksum_value !== want.sum)
          report_err($sformatf("checksum_value %h, want %h on %h", checksum_value, want.sum,
                               want.ch));
      end
    end
  end

  initial begin
    int w;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      pick_wait(rcv_burst, w);
      out_stall <= (w > 0);
      if (w > 0) begin
        repeat (w) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    line_byte_t lb;
    int         dir_reqs;
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = nsf_pkg::REQ_CHAR;
    char_byte    = 8'h00;
    encapsulated = 1'b0;
    out_stall    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      issue(dir_tab[i].req, dir_tab[i].ch, dir_tab[i].enc);
      if (dir_tab[i].fixed) begin
        if (fresh_cnt != int'(dir_tab[i].x_n)) begin
          report_err($sformatf("row %0d queued %0d bytes, table says %0d", i, fresh_cnt,
                               dir_tab[i].x_n));
        end else if (fresh_cnt > 0) begin
          lb = line_q.pop_back();
          lb.ch  = dir_tab[i].x_ch;
          lb.sum = dir_tab[i].x_sum;
          line_q.push_back(lb);
        end
      end
    end
    dir_reqs = req_cnt;
    hold_until_drained();

    while (req_cnt < dir_reqs + RND_ITEMS) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6))
          issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
      end else begin
        random_sentence();
      end
      if ($urandom_range(0, 9) == 0) hold_until_drained();
    end
    in_valid <= 1'b0;

    while (line_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d requests sent (%0d from the table), %0d bytes checked, %0d sentences closed",
             req_cnt, dir_reqs, byte_cnt, close_cnt);
    $display("%0d mismatches over %0d cycles", err_cnt, cyc);
    if (err_cnt == 0) begin
      $display("nmea_sentence_framer_core_tb: clean");
    end else begin
      $display("nmea_sentence_framer_core_tb: errors");
    end
    $finish;
  end

endmodule
